/* design/ftpcs_pkg.sv */
// Shared types, command codes and helpers for the FTP client command sequencer.
package ftpcs_pkg;

  localparam int unsigned CodeW     = 10;
  localparam int unsigned PortW     = 16;
  localparam int unsigned InDataW   = 32;
  localparam int unsigned OutDataW  = 32;

  localparam logic [CodeW-1:0] CodeSvcClosing = 10'd421;
  localparam logic [CodeW-1:0] CodeNoData     = 10'd425;
  localparam logic [CodeW-1:0] CodeXferAbort  = 10'd426;
  localparam logic [CodeW-1:0] CodeBadSeq     = 10'd503;

  // Command codes as they leave the block.
  typedef enum logic [3:0] {
    CMD_NONE = 4'd0,
    CMD_USER = 4'd1,
    CMD_PASS = 4'd2,
    CMD_ACCT = 4'd3,
    CMD_SYST = 4'd4,
    CMD_PWD  = 4'd5,
    CMD_TYPE = 4'd6,
    CMD_PASV = 4'd7,
    CMD_SIZE = 4'd8,
    CMD_RETR = 4'd9,
    CMD_CWD  = 4'd10,
    CMD_LIST = 4'd11,
    CMD_QUIT = 4'd12
  } cmd_e;

  // Last command sent, held one-hot.
  typedef enum logic [12:0] {
    ST_NONE = 13'b0_0000_0000_0001,
    ST_USER = 13'b0_0000_0000_0010,
    ST_PASS = 13'b0_0000_0000_0100,
    ST_ACCT = 13'b0_0000_0000_1000,
    ST_SYST = 13'b0_0000_0001_0000,
    ST_PWD  = 13'b0_0000_0010_0000,
    ST_TYPE = 13'b0_0000_0100_0000,
    ST_PASV = 13'b0_0000_1000_0000,
    ST_SIZE = 13'b0_0001_0000_0000,
    ST_RETR = 13'b0_0010_0000_0000,
    ST_CWD  = 13'b0_0100_0000_0000,
    ST_LIST = 13'b0_1000_0000_0000,
    ST_QUIT = 13'b1_0000_0000_0000
  } st_e;

  typedef struct packed {
    logic             kind;
    logic [CodeW-1:0] reply_code;
    logic             parse_ok;
    logic [7:0]       port_high;
    logic [7:0]       port_low;
  } item_t;

  typedef struct packed {
    cmd_e             next_command;
    logic             open_data;
    logic [PortW-1:0] data_port;
    logic             close_control;
    logic             finished;
    logic             fail;
    logic             listing_set;
  } dec_t;

  function automatic st_e cmd_to_state(cmd_e cmd);
    st_e st;
    st = ST_NONE;
    unique case (cmd)
      CMD_NONE: st = ST_NONE;
      CMD_USER: st = ST_USER;
      CMD_PASS: st = ST_PASS;
      CMD_ACCT: st = ST_ACCT;
      CMD_SYST: st = ST_SYST;
      CMD_PWD:  st = ST_PWD;
      CMD_TYPE: st = ST_TYPE;
      CMD_PASV: st = ST_PASV;
      CMD_SIZE: st = ST_SIZE;
      CMD_RETR: st = ST_RETR;
      CMD_CWD:  st = ST_CWD;
      CMD_LIST: st = ST_LIST;
      CMD_QUIT: st = ST_QUIT;
      default:  st = ST_NONE;
    endcase
    return st;
  endfunction

endpackage

/* design/ftp_client_command_sequencer.sv */
// Top level of the FTP client command sequencer: input register, decision, result register.
//
//  Channel  Direction  Transfer condition          Contents
//  s_axis   in         s_axis_tvalid & tready      kind (tuser), reply code, parse flag, port
//  m_axis   out        m_axis_tvalid & tready      next command, data port, status flags
//
// One transfer can be taken every cycle while m_axis is not stalled; a result passes first
// through the input register and then through the result register.
// The decision for an item is made as it leaves the input register, against the last
// command and failure/listing marks left by the item before it.
// Reset (rst_ni low) returns to awaiting the greeting with both marks clear.
// When m_axis stalls, both registers hold and s_axis_tready drops once both are full.
module ftp_client_command_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [9:0] reply_code, [10] parse_ok, [18:11] port_high, [26:19] port_low, [31:27] zero
  input  logic [ftpcs_pkg::InDataW-1:0]  s_axis_tdata,
  // [0] kind
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] next_command, [4] open_data, [20:5] data_port, [21] close_control,
  // [22] finished, [23] failed, [24] listing, [31:25] zero
  output logic [ftpcs_pkg::OutDataW-1:0] m_axis_tdata
);
  import ftpcs_pkg::*;

  logic  in_valid_q;
  item_t in_q;
  logic  out_valid_q;
  logic [OutDataW-1:0] out_q, out_d;
  st_e   state_q, state_d;
  logic  fail_q, fail_d;
  logic  list_q, list_d;
  logic  advance;
  logic  s_fire;
  dec_t  dec;
  item_t in_d;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign in_d.kind       = s_axis_tuser;
  assign in_d.reply_code = s_axis_tdata[9:0];
  assign in_d.parse_ok   = s_axis_tdata[10];
  assign in_d.port_high  = s_axis_tdata[18:11];
  assign in_d.port_low   = s_axis_tdata[26:19];

  ftpcs_decode u_decode (
    .item_i  (in_q),
    .state_i (state_q),
    .dec_o   (dec)
  );

  always_comb begin
    state_d = state_q;
    fail_d  = fail_q | dec.fail;
    list_d  = list_q | dec.listing_set;
    if (dec.next_command != CMD_NONE) begin
      state_d = cmd_to_state(dec.next_command);
    end
    out_d = {7'd0, list_d, fail_d, dec.finished, dec.close_control,
             dec.data_port, dec.open_data, dec.next_command};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= ST_NONE;
      fail_q      <= 1'b0;
      list_q      <= 1'b0;
    end else begin
      if (s_fire) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
        fail_q      <= fail_d;
        list_q      <= list_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_q <= in_d;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // A failure mark, once taken, is never dropped before reset.
  a_fail_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fail_q |=> fail_q)
    else $error("failure mark cleared without reset");

  // A result that opens the data connection or finishes never also sends a command.
  a_no_cmd_with_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[4] || (m_axis_tdata[22] && !m_axis_tdata[21])))
      |-> (m_axis_tdata[3:0] == CMD_NONE))
    else $error("command issued together with data open or plain finish");

  // The data port is only nonzero when the data connection is requested.
  a_port_only_on_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[4]) |-> (m_axis_tdata[20:5] == '0))
    else $error("data port present without open request");

  // A decided failure always sends QUIT.
  a_fail_quit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && dec.fail) |=> (m_axis_tdata[3:0] == CMD_QUIT) && fail_q)
    else $error("failure did not send QUIT");

endmodule

/* design/ftpcs_decode.sv */
// Reply and data-event decision table of the FTP client command sequencer.
module ftpcs_decode (
  input  ftpcs_pkg::item_t item_i,
  input  ftpcs_pkg::st_e   state_i,
  output ftpcs_pkg::dec_t  dec_o
);
  import ftpcs_pkg::*;

  logic [CodeW-1:0] code;
  logic c1, c2, c3, c4, c5;
  logic fail;
  cmd_e next;
  dec_t dec;

  assign code = item_i.reply_code;

  // Reply class is the first digit; codes below 100 or above 599 fall in no class.
  assign c1 = (code >= 10'd100) && (code < 10'd200);
  assign c2 = (code >= 10'd200) && (code < 10'd300);
  assign c3 = (code >= 10'd300) && (code < 10'd400);
  assign c4 = (code >= 10'd400) && (code < 10'd500);
  assign c5 = (code >= 10'd500) && (code < 10'd600);

  always_comb begin
    dec  = '0;
    next = CMD_NONE;
    fail = 1'b0;
    if (item_i.kind) begin
      if (state_i == ST_PASV) begin
        next = CMD_SIZE;
      end
    end else begin
      unique case (state_i)
        ST_NONE: next = CMD_USER;
        ST_USER: begin
          if (c1 || c2) next = CMD_USER;
          else if (c3) next = CMD_PASS;
          else fail = 1'b1;
        end
        ST_PASS: begin
          if (c1 || c2) next = CMD_SYST;
          else if (c3) next = CMD_ACCT;
          else if (code == CodeBadSeq) next = CMD_PASS;
          else fail = 1'b1;
        end
        ST_ACCT: begin
          if (c2) next = CMD_SYST;
          else fail = 1'b1;
        end
        ST_SYST: next = CMD_PWD;
        ST_PWD: begin
          if (c2) next = CMD_TYPE;
          else fail = 1'b1;
        end
        ST_TYPE: begin
          if (c2) next = CMD_PASV;
          else fail = 1'b1;
        end
        ST_PASV: begin
          if (c2 && item_i.parse_ok) begin
            dec.open_data = 1'b1;
            dec.data_port = {item_i.port_high, item_i.port_low};
          end else begin
            fail = 1'b1;
          end
        end
        ST_SIZE: begin
          if (c2) begin
            if (item_i.parse_ok) next = CMD_RETR;
            else fail = 1'b1;
          end else if (c1 || c3 || c4 || c5) begin
            next = CMD_LIST;
          end else begin
            fail = 1'b1;
          end
        end
        ST_RETR: begin
          // Every 4xx here, including 421, 425 and 426, ends in failure.
          if (c1) begin
            next = CMD_QUIT;
            dec.close_control = 1'b1;
          end else if (c2) begin
            dec.finished = 1'b1;
          end else if (c3) begin
            next = CMD_PASV;
          end else if (c5) begin
            next = CMD_CWD;
          end else begin
            fail = 1'b1;
          end
        end
        ST_CWD: begin
          if (c2) next = CMD_LIST;
          else fail = 1'b1;
        end
        ST_LIST: begin
          if (c1 || c2) begin
            next = CMD_QUIT;
            dec.listing_set = 1'b1;
          end else begin
            fail = 1'b1;
          end
        end
        ST_QUIT: begin
          dec.close_control = 1'b1;
          dec.finished      = 1'b1;
        end
        default: fail = 1'b1;
      endcase
    end
    if (fail) begin
      next = CMD_QUIT;
    end
    dec.fail         = fail;
    dec.next_command = next;
  end

  assign dec_o = dec;

endmodule

/* tb/sv/ftp_client_command_sequencer_tb.sv */
// Self-checking testbench for the FTP client command sequencer.
`timescale 1ns / 1ps

module ftp_client_command_sequencer_tb;
  import ftpcs_pkg::*;

  typedef struct packed {
    cmd_e        cmd;
    logic        open_data;
    logic [15:0] data_port;
    logic        close_control;
    logic        finished;
    logic        failed;
    logic        listing;
  } reply_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  // Session state as the client sees it.
  cmd_e   sess_last    = CMD_NONE;
  logic   sess_failing = 1'b0;
  logic   sess_listed  = 1'b0;

  reply_t      expected_q[$];
  int unsigned mismatches = 0;
  bit          idling = 1'b1;
  int unsigned rx_stall_left = 0;

  ftp_client_command_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Decides the client's next step for one event and updates the session state.
  function automatic reply_t advance_session(input item_t it);
    reply_t      r;
    int unsigned cls;
    logic        bad;
    r   = '0;
    bad = 1'b0;
    cls = it.reply_code / 100;
    r.cmd = CMD_NONE;
    if (it.kind) begin
      if (sess_last == CMD_PASV) r.cmd = CMD_SIZE;
    end else begin
      case (sess_last)
        CMD_NONE: r.cmd = CMD_USER;
        CMD_USER: begin
          if (cls == 1 || cls == 2) r.cmd = CMD_USER;
          else if (cls == 3) r.cmd = CMD_PASS;
          else bad = 1'b1;
        end
        CMD_PASS: begin
          if (cls == 1 || cls == 2) r.cmd = CMD_SYST;
          else if (cls == 3) r.cmd = CMD_ACCT;
          else if (it.reply_code == CodeBadSeq) r.cmd = CMD_PASS;
          else bad = 1'b1;
        end
        CMD_ACCT: if (cls == 2) r.cmd = CMD_SYST; else bad = 1'b1;
        CMD_SYST: r.cmd = CMD_PWD;
        CMD_PWD:  if (cls == 2) r.cmd = CMD_TYPE; else bad = 1'b1;
        CMD_TYPE: if (cls == 2) r.cmd = CMD_PASV; else bad = 1'b1;
        CMD_PASV: begin
          if (cls == 2 && it.parse_ok) begin
            r.open_data = 1'b1;
            r.data_port = {it.port_high, it.port_low};
          end else begin
            bad = 1'b1;
          end
        end
        CMD_SIZE: begin
          if (cls == 2) begin
            if (it.parse_ok) r.cmd = CMD_RETR; else bad = 1'b1;
          end else if (cls >= 1 && cls <= 5) begin
            r.cmd = CMD_LIST;
          end else begin
            bad = 1'b1;
          end
        end
        CMD_RETR: begin
          if (cls == 1) begin
            r.cmd = CMD_QUIT;
            r.close_control = 1'b1;
          end else if (cls == 2) r.finished = 1'b1;
          else if (cls == 3) r.cmd = CMD_PASV;
          else if (cls == 5) r.cmd = CMD_CWD;
          else bad = 1'b1;
        end
        CMD_CWD:  if (cls == 2) r.cmd = CMD_LIST; else bad = 1'b1;
        CMD_LIST: begin
          if (cls == 1 || cls == 2) begin
            r.cmd = CMD_QUIT;
            sess_listed = 1'b1;
          end else begin
            bad = 1'b1;
          end
        end
        CMD_QUIT: begin
          r.close_control = 1'b1;
          r.finished      = 1'b1;
        end
        default: bad = 1'b1;
      endcase
    end
    if (bad) begin
      r.cmd = CMD_QUIT;
      sess_failing = 1'b1;
    end
    if (r.cmd != CMD_NONE) sess_last = r.cmd;
    r.failed  = sess_failing;
    r.listing = sess_listed;
    return r;
  endfunction

  function automatic item_t reply_item(input int unsigned code, input bit pok = 1'b0,
                                       input logic [7:0] ph = 8'h00,
                                       input logic [7:0] pl = 8'h00);
    item_t it;
    it.kind       = 1'b0;
    it.reply_code = code[CodeW-1:0];
    it.parse_ok   = pok;
    it.port_high  = ph;
    it.port_low   = pl;
    return it;
  endfunction

  // Reply of a given class with random detail digits and port bytes.
  function automatic item_t class_reply(input int unsigned cls, input bit pok);
    return reply_item(cls * 100 + $urandom_range(0, 99), pok,
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endfunction

  function automatic item_t any_item();
    item_t it;
    it = class_reply($urandom_range(0, 9), 1'($urandom_range(0, 1)));
    it.kind = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic item_t connect_event();
    item_t it;
    it = any_item();
    it.kind = 1'b1;
    return it;
  endfunction

  // Reply whose class is not one of those set in ok_mask (bit n stands for class n).
  function automatic item_t reply_outside(input logic [9:0] ok_mask);
    int unsigned cls;
    do cls = $urandom_range(0, 9); while (ok_mask[cls]);
    return class_reply(cls, 1'($urandom_range(0, 1)));
  endfunction

  // An event that keeps the transfer loop (PASV, SIZE, RETR) going.
  function automatic item_t next_live_item(input cmd_e at);
    item_t it;
    it = class_reply(2, 1'b1);
    case (at)
      CMD_PASV: begin
        if ($urandom_range(0, 1) == 1) it = connect_event();
      end
      CMD_RETR: it = class_reply(($urandom_range(0, 9) < 6) ? 3 : 2,
                                 1'($urandom_range(0, 1)));
      default: ;
    endcase
    return it;
  endfunction

  task automatic send_item(input item_t it);
    int unsigned gap;
    @(negedge clk_i);
    if (idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, it.port_low, it.port_high, it.parse_ok, it.reply_code};
    s_axis_tuser  <= it.kind;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(advance_session(it));
  endtask

  task automatic note_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic compare_field(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want) note_mismatch(what, got, want);
  endtask

  // Receiver stalls in random bursts while idling is allowed.
  always @(negedge clk_i) begin
    if (!idling) begin
      rx_stall_left = 0;
      m_axis_tready <= 1'b1;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      rx_stall_left = $urandom_range(1, 9) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        note_mismatch("unexpected result", m_axis_tdata[15:0], 16'h0);
      end else begin
        want = expected_q.pop_front();
        compare_field("next_command",  16'(m_axis_tdata[3:0]),   16'(want.cmd));
        compare_field("open_data",     16'(m_axis_tdata[4]),     16'(want.open_data));
        compare_field("data_port",     m_axis_tdata[20:5],       want.data_port);
        compare_field("close_control", 16'(m_axis_tdata[21]),    16'(want.close_control));
        compare_field("finished",      16'(m_axis_tdata[22]),    16'(want.finished));
        compare_field("failed",        16'(m_axis_tdata[23]),    16'(want.failed));
        compare_field("listing",       16'(m_axis_tdata[24]),    16'(want.listing));
        compare_field("padding",       16'(m_axis_tdata[31:25]), 16'h0);
      end
    end
  end

  // Greeting and login, including a data event before anything was sent.
  task automatic test_login_sequence();
    send_item(connect_event());
    send_item(reply_item(0));
    send_item(reply_item(120));
    send_item(reply_item(230));
    send_item(reply_item(331));
    send_item(reply_item(32'(CodeBadSeq)));
    send_item(reply_item(332));
    send_item(reply_item(230));
    // Any reply to SYST moves on, even one of no valid class.
    send_item(reply_item(999, 1'b1, 8'hff, 8'hff));
    send_item(reply_item(257));
    send_item(reply_item(200));
  endtask

  task automatic test_passive_open();
    item_t ev;
    send_item(reply_item(227, 1'b1, 8'hff, 8'hff));
    send_item(reply_item(299, 1'b1, 8'h00, 8'h00));
    ev = reply_item(999, 1'b1, 8'hff, 8'hff);
    ev.kind = 1'b1;
    send_item(ev);
  endtask

  task automatic test_retrieve_loop();
    item_t ev;
    ev = reply_item(0);
    ev.kind = 1'b1;
    send_item(ev);
    send_item(reply_item(213, 1'b1));
    send_item(reply_item(226));
    // A second reply after the transfer completed is decoded against RETR again.
    send_item(reply_item(250));
    send_item(reply_item(350));
    send_item(reply_item(227, 1'b1, 8'h12, 8'h34));
    send_item(ev);
    send_item(reply_item(200, 1'b1, 8'h5a, 8'ha5));
  endtask

  task automatic test_random_session();
    int unsigned counted;
    counted = 0;
    while (counted < 300) begin
      if ($urandom_range(0, 39) == 0) idling = !idling;
      if (sess_last != CMD_PASV && $urandom_range(0, 7) == 0) begin
        send_item(connect_event());
      end else begin
        send_item(next_live_item(sess_last));
        counted++;
      end
    end
    idling = 1'b1;
  endtask

  task automatic end_listing();
    if ($urandom_range(0, 1) == 1) send_item(class_reply($urandom_range(1, 2), 1'b0));
    else send_item(reply_outside(10'b00_0000_0110));
  endtask

  // Leaves the transfer loop by one randomly chosen way, then talks to a closing session.
  task automatic test_session_end();
    int unsigned pick;
    int unsigned cls;
    cmd_e        target;
    item_t       it;
    pick   = $urandom_range(0, 6);
    target = (pick == 0) ? CMD_PASV : (pick <= 2) ? CMD_SIZE : CMD_RETR;
    while (sess_last != target) send_item(next_live_item(sess_last));
    case (pick)
      0: begin
        if ($urandom_range(0, 1) == 1) send_item(class_reply(2, 1'b0));
        else send_item(reply_outside(10'b00_0000_0100));
      end
      1: begin
        if ($urandom_range(0, 1) == 1) send_item(class_reply(2, 1'b0));
        else send_item(reply_outside(10'b00_0011_1110));
      end
      2: begin
        cls = $urandom_range(0, 3);
        send_item(class_reply((cls == 0) ? 1 : cls + 2, 1'($urandom_range(0, 1))));
        end_listing();
      end
      3: send_item(class_reply(1, 1'($urandom_range(0, 1))));
      4: begin
        case ($urandom_range(0, 4))
          0: it = reply_item(32'(CodeSvcClosing));
          1: it = reply_item(32'(CodeNoData));
          2: it = reply_item(32'(CodeXferAbort));
          3: it = class_reply(4, 1'($urandom_range(0, 1)));
          default: it = reply_outside(10'b00_0010_1110);
        endcase
        send_item(it);
      end
      5: begin
        send_item(class_reply(5, 1'($urandom_range(0, 1))));
        send_item(class_reply(2, 1'($urandom_range(0, 1))));
        end_listing();
      end
      default: begin
        send_item(class_reply(5, 1'($urandom_range(0, 1))));
        send_item(reply_outside(10'b00_0000_0100));
      end
    endcase
    idling = 1'b0;
    repeat (40) send_item(any_item());
  endtask

  initial begin
    int unsigned guard;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_login_sequence();
    test_passive_open();
    test_retrieve_loop();
    test_random_session();
    test_session_end();

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    for (guard = 0; guard < 2000 && expected_q.size() != 0; guard++) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      note_mismatch("results never arrived", 16'(expected_q.size()), 16'h0);
    end

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* sim.f */
design/ftpcs_pkg.sv
design/ftpcs_decode.sv
design/ftp_client_command_sequencer.sv
tb/sv/ftp_client_command_sequencer_tb.sv
